FILE: sv/b64e_pkg.sv
// Shared types and constants of the base64 line-wrapped encoder.
// Depends on nothing; imported by every other file of the block.
package b64e_pkg;

    localparam int CHAR_W  = 7;
    localparam int LG_W    = 6;
    localparam int SLOT_W  = 3;

    localparam logic [CHAR_W-1:0] CHR_CR   = 7'd13;
    localparam logic [CHAR_W-1:0] CHR_LF   = 7'd10;
    localparam logic [CHAR_W-1:0] CHR_PAD  = 7'd61;
    localparam logic [CHAR_W-1:0] CHR_PLUS = 7'd43;
    localparam logic [CHAR_W-1:0] CHR_SLSH = 7'd47;
    localparam logic [CHAR_W-1:0] CHR_UA   = 7'd65;
    localparam logic [CHAR_W-1:0] CHR_LA   = 7'd97;
    localparam logic [CHAR_W-1:0] CHR_D0   = 7'd48;

    localparam logic [LG_W-1:0] LG_RESET = 6'd16;
    localparam logic [LG_W-1:0] GOL_MAX  = 6'd63;

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;

    localparam logic [SLOT_W-1:0] SLOT_CR   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_LF   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_C0   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_C1   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_C2   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd5;

    // One finished group on its way to the serializer.
    typedef struct packed {
        logic                        crlf;
        logic                        last;
        logic [3:0][CHAR_W-1:0]      chars;
    } grp_t;

    function automatic logic [CHAR_W-1:0] sym(input logic [5:0] idx);
        logic [CHAR_W-1:0] v;
        v = {1'b0, idx};
        if (idx < 6'd26) begin
            sym = CHR_UA + v;
        end else if (idx < 6'd52) begin
            sym = CHR_LA + v - 7'd26;
        end else if (idx < 6'd62) begin
            sym = CHR_D0 + v - 7'd52;
        end else if (idx == 6'd62) begin
            sym = CHR_PLUS;
        end else begin
            sym = CHR_SLSH;
        end
    endfunction

endpackage

FILE: sv/b64e_group.sv
// Byte gatherer: collects up to three bytes, maps them to four characters,
// tracks line position. Depends on b64e_pkg.
module b64e_group (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [b64e_pkg::LG_W-1:0]   line_groups,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_final_byte,
    output logic                        grp_valid,
    input  logic                        grp_ready,
    output b64e_pkg::grp_t              grp
);
    import b64e_pkg::*;

    logic [15:0]      held_reg, held_next;
    logic [1:0]       phase_reg, phase_next;
    logic [LG_W-1:0]  gol_reg, gol_next;
    logic             nf_reg, nf_next;
    logic             gv_reg, gv_next;
    grp_t             grp_reg, grp_next;

    logic             take, emit, crlf;
    logic [7:0]       b0, b1, b2;
    logic [1:0]       nbytes;
    logic [LG_W-1:0]  gol_base;

    assign s_ready   = !gv_reg || grp_ready;
    assign take      = s_valid && s_ready;
    assign emit      = take && (s_final_byte || (phase_reg != PH_EMPTY && phase_reg != PH_ONE));
    assign crlf      = nf_reg && (line_groups != '0) && (gol_reg >= line_groups);
    assign grp_valid = gv_reg;
    assign grp       = grp_reg;

    always_comb begin
        unique case (phase_reg)
            PH_EMPTY: begin
                b0 = s_data_byte;    b1 = 8'd0;           b2 = 8'd0;        nbytes = 2'd1;
            end
            PH_ONE: begin
                b0 = held_reg[15:8]; b1 = s_data_byte;    b2 = 8'd0;        nbytes = 2'd2;
            end
            default: begin
                b0 = held_reg[15:8]; b1 = held_reg[7:0];  b2 = s_data_byte; nbytes = 2'd3;
            end
        endcase
    end

    always_comb begin
        held_next  = held_reg;
        phase_next = phase_reg;
        gol_next   = gol_reg;
        nf_next    = nf_reg;
        gv_next    = grp_ready ? 1'b0 : gv_reg;
        grp_next   = grp_reg;
        gol_base   = crlf ? '0 : gol_reg;

        if (emit) begin
            gv_next           = 1'b1;
            grp_next.crlf     = crlf;
            grp_next.last     = s_final_byte;
            grp_next.chars[0] = sym(b0[7:2]);
            grp_next.chars[1] = sym({b0[1:0], b1[7:4]});
            grp_next.chars[2] = (nbytes >= 2'd2) ? sym({b1[3:0], b2[7:6]}) : CHR_PAD;
            grp_next.chars[3] = (nbytes == 2'd3) ? sym(b2[5:0]) : CHR_PAD;
            phase_next        = PH_EMPTY;
            if (s_final_byte) begin
                gol_next = '0;
                nf_next  = 1'b0;
            end else begin
                gol_next = (gol_base < GOL_MAX) ? gol_base + 1'b1 : gol_base;
                nf_next  = 1'b1;
            end
        end else if (take) begin
            if (phase_reg == PH_EMPTY) begin
                held_next[15:8] = s_data_byte;
                phase_next      = PH_ONE;
            end else begin
                held_next[7:0]  = s_data_byte;
                phase_next      = PH_TWO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_EMPTY;
            gol_reg   <= '0;
            nf_reg    <= 1'b0;
            gv_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            gol_reg   <= gol_next;
            nf_reg    <= nf_next;
            gv_reg    <= gv_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        grp_reg  <= grp_next;
    end

endmodule

FILE: sv/b64e_serial.sv
// Character serializer: sends CR/LF and a group's four characters, one
// beat per cycle unless stalled, from an output register; uses b64e_pkg.
module b64e_serial (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          grp_valid,
    output logic                          grp_ready,
    input  b64e_pkg::grp_t                grp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [b64e_pkg::CHAR_W-1:0]   m_ascii_char,
    output logic                          m_final_char
);
    import b64e_pkg::*;

    grp_t               rec_reg, rec_next;
    logic               busy_reg, busy_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               mv_reg, mv_next;
    logic [CHAR_W-1:0]  chr_reg, chr_next;
    logic               fin_reg, fin_next;

    logic               out_free, step, last_step, load;
    logic [CHAR_W-1:0]  sel_char;

    assign out_free  = !mv_reg || m_ready;
    assign step      = busy_reg && out_free;
    assign last_step = step && (slot_reg == SLOT_LAST);
    assign grp_ready = !busy_reg || last_step;
    assign load      = grp_valid && grp_ready;

    assign m_valid      = mv_reg;
    assign m_ascii_char = chr_reg;
    assign m_final_char = fin_reg;

    always_comb begin
        unique case (slot_reg)
            SLOT_LF:   sel_char = CHR_LF;
            SLOT_C0:   sel_char = rec_reg.chars[0];
            SLOT_C1:   sel_char = rec_reg.chars[1];
            SLOT_C2:   sel_char = rec_reg.chars[2];
            SLOT_LAST: sel_char = rec_reg.chars[3];
            default:   sel_char = CHR_CR;
        endcase
    end

    always_comb begin
        rec_next  = rec_reg;
        busy_next = busy_reg;
        slot_next = slot_reg;
        mv_next   = m_ready ? 1'b0 : mv_reg;
        chr_next  = chr_reg;
        fin_next  = fin_reg;

        if (step) begin
            mv_next   = 1'b1;
            chr_next  = sel_char;
            fin_next  = rec_reg.last && (slot_reg == SLOT_LAST);
            slot_next = slot_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            rec_next  = grp;
            busy_next = 1'b1;
            slot_next = grp.crlf ? SLOT_CR : SLOT_C0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            slot_reg <= SLOT_C0;
            mv_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        chr_reg <= chr_next;
        fin_reg <= fin_next;
    end

endmodule

FILE: sv/base64_line_wrapped_encoder.sv
// Top level of the base64 encoder with CRLF line wrapping.
// Depends on b64e_pkg, b64e_group and b64e_serial.
//
// Bytes enter one beat per cycle while s_ready holds; every third byte, or
// the byte flagged final, closes a group that leaves as four characters
// ('=' padded), led by CR and LF when the previous line holds cfg_data
// groups (zero: no wrapping), so six characters with a line break. The
// serializer sends one character per cycle while m_ready holds. One
// finished group waits in a register between the byte gatherer and the
// serializer, so input keeps flowing while characters drain. A group then
// passes the serializer's record register and its output register in turn.
// cfg_data is taken at any time but must only change while the block is idle.
module base64_line_wrapped_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [b64e_pkg::LG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_final_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [b64e_pkg::CHAR_W-1:0]   m_ascii_char,
    output logic                          m_final_char
);
    import b64e_pkg::*;

    logic [LG_W-1:0]  line_groups_reg, line_groups_next;
    logic             grp_valid, grp_ready;
    grp_t             grp;

    assign cfg_ready        = 1'b1;
    assign line_groups_next = (cfg_valid && cfg_ready) ? cfg_data : line_groups_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_groups_reg <= LG_RESET;
        end else begin
            line_groups_reg <= line_groups_next;
        end
    end

    b64e_group u_group (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .line_groups  (line_groups_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .grp_valid    (grp_valid),
        .grp_ready    (grp_ready),
        .grp          (grp)
    );

    b64e_serial u_serial (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .grp_valid    (grp_valid),
        .grp_ready    (grp_ready),
        .grp          (grp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_final_char (m_final_char)
    );

endmodule

FILE: sv/b64e_checker.sv
// Port-level checks for the base64 encoder, bound to the top level.
// Depends on b64e_pkg and base64_line_wrapped_encoder.
module b64e_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [b64e_pkg::CHAR_W-1:0]   m_ascii_char,
    input  logic                          m_final_char
);
    import b64e_pkg::*;

    logic m_beat, is_sym;

    assign m_beat = m_valid && m_ready;
    assign is_sym = (m_ascii_char >= CHR_UA && m_ascii_char <= 7'd90)
                 || (m_ascii_char >= CHR_LA && m_ascii_char <= 7'd122)
                 || (m_ascii_char >= CHR_D0 && m_ascii_char <= 7'd57)
                 || m_ascii_char == CHR_PLUS || m_ascii_char == CHR_SLSH;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ascii_char) && $stable(m_final_char))
        else $error("output beat changed while stalled");

    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> is_sym || m_ascii_char == CHR_PAD
                    || m_ascii_char == CHR_CR || m_ascii_char == CHR_LF)
        else $error("illegal output character");

    a_crlf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_ascii_char == CHR_CR |=> m_valid && m_ascii_char == CHR_LF)
        else $error("CR not followed by LF");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_ascii_char == CHR_PAD && !m_final_char
        |=> m_valid && m_ascii_char == CHR_PAD && m_final_char)
        else $error("double pad not closing the message");

endmodule

bind base64_line_wrapped_encoder b64e_checker u_b64e_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_ascii_char (m_ascii_char),
    .m_final_char (m_final_char)
);
